// File: hw/rtl/mppt_pkg.sv
// Shared types, codes and helpers for the MPPT tracker with IV sweep.
`default_nettype none
package mppt_pkg;

	// Depth of the sweep point store.
	localparam int SWEEP_POINTS = 64;

	// Operation codes of an input beat.
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_MODE  = 2'd1;
	localparam logic [1:0] OP_SWEEP = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	// Operating modes.
	localparam logic [1:0] MODE_MANUAL = 2'd0;
	localparam logic [1:0] MODE_AUTO   = 2'd1;
	localparam logic [1:0] MODE_SWEEP  = 2'd2;

	// Sweep phases.
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_ARM    = 2'd1;
	localparam logic [1:0] PH_SAMPLE = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 20;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EPSILON    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TRACK_STEP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_MIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_MAX  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_STEP = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FINAL_DUTY = 3'd6;

	localparam logic [9:0] DUTY_MAX = 10'd1000;

	typedef struct packed {
		logic [1:0]  op;
		logic [1:0]  new_mode;
		logic [15:0] volt_in;
		logic [15:0] amp_in;
		logic [19:0] power_in;
		logic [5:0]  point_index;
	} in_t;

	typedef struct packed {
		logic [9:0]  duty_out;
		logic [1:0]  mode_out;
		logic        direction_up;
		logic        sweep_busy;
		logic        sweep_done;
		logic [6:0]  points_stored;
		logic [15:0] point_volt;
		logic [15:0] point_amp;
	} out_t;

	// Controller status that forms the scalar part of a result.
	typedef struct packed {
		logic [9:0] duty;
		logic [1:0] mode;
		logic       dir_up;
		logic       busy;
		logic       done;
		logic [6:0] points;
	} status_t;

	// Clamp an 11-bit duty value to the legal range.
	function automatic logic [9:0] cap_duty(input logic [10:0] d);
		logic [9:0] r;
		if (d > {1'b0, DUTY_MAX}) begin
			r = DUTY_MAX;
		end else begin
			r = d[9:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/mppt_pts_mem.sv
// Sweep point store: one write port and one registered read port.
`default_nettype none
module mppt_pts_mem #(
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [31:0]              wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [31:0]                   rd_data
);
	logic [31:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port, enabled by rd_en.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/mppt_ctrl.sv
// Tracker and sweep controller: configuration, scalar state and point store access.
`default_nettype none
module mppt_ctrl (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   accept,
	input  wire mppt_pkg::in_t                          item,
	input  wire logic                                   cfg_we,
	input  wire logic [mppt_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [mppt_pkg::CFG_DATA_W-1:0]        cfg_data,
	output mppt_pkg::status_t                           status,
	output logic                                        pt_we,
	output logic [$clog2(mppt_pkg::SWEEP_POINTS)-1:0]   pt_waddr,
	output logic [31:0]                                 pt_wdata,
	output logic                                        pt_re,
	output logic [$clog2(mppt_pkg::SWEEP_POINTS)-1:0]   pt_raddr,
	output logic                                        pt_hit
);
	import mppt_pkg::*;

	localparam int IW = $clog2(SWEEP_POINTS);
	localparam int CW = $clog2(SWEEP_POINTS + 1);

	// Configuration registers.
	logic [15:0] period_q;
	logic [19:0] epsilon_q;
	logic [9:0]  track_step_q;
	logic [9:0]  sweep_min_q;
	logic [9:0]  sweep_max_q;
	logic [9:0]  sweep_step_q;
	logic [9:0]  final_duty_q;

	// Scalar state.
	logic [9:0]    duty_q, duty_d;
	logic [1:0]    mode_q, mode_d;
	logic [19:0]   last_power_q, last_power_d;
	logic          dir_up_q, dir_up_d;
	logic [15:0]   track_el_q, track_el_d;
	logic [15:0]   sweep_el_q, sweep_el_d;
	logic [1:0]    phase_q, phase_d;
	logic [IW-1:0] index_q, index_d;
	logic [CW-1:0] count_q, count_d;
	logic          final_q, final_d;

	logic [15:0] track_inc;
	logic [15:0] sweep_inc;
	logic        drop;
	logic        finish;
	logic        last_point;
	logic [10:0] duty_up;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q     <= 16'd1;
			epsilon_q    <= 20'd10;
			track_step_q <= 10'd10;
			sweep_min_q  <= 10'd0;
			sweep_max_q  <= 10'd1000;
			sweep_step_q <= 10'd10;
			final_duty_q <= 10'd1000;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PERIOD:     period_q     <= cfg_data[15:0];
				CFG_EPSILON:    epsilon_q    <= cfg_data;
				CFG_TRACK_STEP: track_step_q <= cfg_data[9:0];
				CFG_SWEEP_MIN:  sweep_min_q  <= cfg_data[9:0];
				CFG_SWEEP_MAX:  sweep_max_q  <= cfg_data[9:0];
				CFG_SWEEP_STEP: sweep_step_q <= cfg_data[9:0];
				CFG_FINAL_DUTY: final_duty_q <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	// Saturating tick counters and the perturb and observe decision.
	assign track_inc  = (track_el_q == 16'hFFFF) ? track_el_q : track_el_q + 16'd1;
	assign sweep_inc  = (sweep_el_q == 16'hFFFF) ? sweep_el_q : sweep_el_q + 16'd1;
	assign drop       = (last_power_q > item.power_in) &&
	                    ((last_power_q - item.power_in) >= epsilon_q);
	assign last_point = (CW'(index_q) + CW'(1)) >= CW'(SWEEP_POINTS);
	assign duty_up    = {1'b0, duty_q} + {1'b0, sweep_step_q};

	// Next state for one accepted beat.
	always_comb begin
		duty_d       = duty_q;
		mode_d       = mode_q;
		last_power_d = last_power_q;
		dir_up_d     = dir_up_q;
		track_el_d   = track_el_q;
		sweep_el_d   = sweep_el_q;
		phase_d      = phase_q;
		index_d      = index_q;
		count_d      = count_q;
		final_d      = final_q;
		finish       = 1'b0;
		pt_we        = 1'b0;
		pt_re        = 1'b0;
		pt_hit       = 1'b0;
		case (item.op)
			OP_TICK: begin
				track_el_d = track_inc;
				sweep_el_d = sweep_inc;
				if (mode_q == MODE_AUTO && track_inc >= period_q) begin
					track_el_d   = 16'd0;
					last_power_d = item.power_in;
					dir_up_d     = dir_up_q ^ drop;
					if (dir_up_q ^ drop) begin
						duty_d = cap_duty({1'b0, duty_q} + {1'b0, track_step_q});
					end else if (duty_q >= track_step_q) begin
						duty_d = duty_q - track_step_q;
					end else begin
						duty_d = 10'd0;
					end
				end else if (mode_q == MODE_SWEEP && sweep_inc >= period_q) begin
					sweep_el_d = 16'd0;
					case (phase_q)
						PH_IDLE: begin
						end
						PH_ARM: begin
							duty_d  = cap_duty({1'b0, sweep_min_q});
							index_d = '0;
							count_d = '0;
							phase_d = PH_SAMPLE;
						end
						PH_SAMPLE: begin
							pt_we   = accept;
							count_d = CW'(index_q) + CW'(1);
							if (last_point || duty_q >= cap_duty({1'b0, sweep_max_q})) begin
								phase_d = PH_DONE;
								finish  = 1'b1;
							end else begin
								index_d = index_q + IW'(1);
								duty_d  = cap_duty(duty_up);
							end
						end
						default: finish = 1'b1;
					endcase
					// Final duty is applied once per sweep.
					if (finish && !final_q) begin
						final_d = 1'b1;
						duty_d  = cap_duty({1'b0, final_duty_q});
						mode_d  = MODE_MANUAL;
					end
				end
			end
			OP_MODE: begin
				if (item.new_mode inside {MODE_MANUAL, MODE_AUTO, MODE_SWEEP}) begin
					mode_d = item.new_mode;
					if (item.new_mode == MODE_AUTO) begin
						dir_up_d     = 1'b1;
						last_power_d = item.power_in;
					end
				end
			end
			OP_SWEEP: begin
				final_d    = 1'b0;
				mode_d     = MODE_SWEEP;
				phase_d    = PH_ARM;
				index_d    = '0;
				count_d    = '0;
				sweep_el_d = 16'hFFFF;
			end
			default: begin
				pt_re  = accept;
				pt_hit = 11'(item.point_index) < 11'(count_q);
			end
		endcase
	end

	// State registers advance on each accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q       <= 10'd0;
			mode_q       <= MODE_MANUAL;
			last_power_q <= 20'd0;
			dir_up_q     <= 1'b1;
			track_el_q   <= 16'd0;
			sweep_el_q   <= 16'd0;
			phase_q      <= PH_IDLE;
			index_q      <= '0;
			count_q      <= '0;
			final_q      <= 1'b0;
		end else if (accept) begin
			duty_q       <= duty_d;
			mode_q       <= mode_d;
			last_power_q <= last_power_d;
			dir_up_q     <= dir_up_d;
			track_el_q   <= track_el_d;
			sweep_el_q   <= sweep_el_d;
			phase_q      <= phase_d;
			index_q      <= index_d;
			count_q      <= count_d;
			final_q      <= final_d;
		end
	end

	// Point store addressing.
	assign pt_waddr = index_q;
	assign pt_wdata = {item.volt_in, item.amp_in};
	assign pt_raddr = IW'(item.point_index);

	// Status as it stands after the last accepted beat.
	assign status.duty   = duty_q;
	assign status.mode   = mode_q;
	assign status.dir_up = dir_up_q;
	assign status.busy   = (phase_q == PH_ARM) || (phase_q == PH_SAMPLE);
	assign status.done   = (phase_q == PH_DONE);
	assign status.points = 7'(count_q);
endmodule
`default_nettype wire

// File: hw/rtl/mppt_perturb_observe_with_iv_sweep.sv
// A result passes through stage 1 and then the result register; the point store is read
// and written in the accept cycle. Throughput: one beat per cycle unless output stalls.
// The result register decouples the output; stage 1 takes a beat while a result waits.
// Reset clears the controller state and configuration; the point store is not cleared.
// Top level of the MPPT tracker with IV sweep.
`default_nettype none
module mppt_perturb_observe_with_iv_sweep (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire mppt_pkg::in_t                    in_data,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output mppt_pkg::out_t                        out_data,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [mppt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [mppt_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mppt_pkg::*;

	localparam int IW = $clog2(SWEEP_POINTS);

	logic          accept;
	logic          s1_adv;
	logic          valid_s1;
	logic          hit_s1;
	logic          out_valid_q;
	out_t          out_data_q;
	status_t       status;
	logic          pt_we;
	logic [IW-1:0] pt_waddr;
	logic [31:0]   pt_wdata;
	logic          pt_re;
	logic [IW-1:0] pt_raddr;
	logic          pt_hit;
	logic [31:0]   pt_rdata;

	assign cfg_ready = 1'b1;
	assign s1_adv    = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || s1_adv;
	assign accept    = in_valid && in_ready;

	mppt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (in_data),
		.cfg_we   (cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.status   (status),
		.pt_we    (pt_we),
		.pt_waddr (pt_waddr),
		.pt_wdata (pt_wdata),
		.pt_re    (pt_re),
		.pt_raddr (pt_raddr),
		.pt_hit   (pt_hit)
	);

	mppt_pts_mem #(
		.DEPTH(SWEEP_POINTS)
	) u_pts_mem (
		.clk    (clk),
		.wr_en  (pt_we),
		.wr_addr(pt_waddr),
		.wr_data(pt_wdata),
		.rd_en  (pt_re),
		.rd_addr(pt_raddr),
		.rd_data(pt_rdata)
	);

	// Stage 1 waits for the point read; it holds until the result register frees up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			hit_s1   <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			hit_s1   <= pt_hit;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload: controller status plus the read point, zero on a miss.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_data_q.duty_out      <= status.duty;
			out_data_q.mode_out      <= status.mode;
			out_data_q.direction_up  <= status.dir_up;
			out_data_q.sweep_busy    <= status.busy;
			out_data_q.sweep_done    <= status.done;
			out_data_q.points_stored <= status.points;
			out_data_q.point_volt    <= hit_s1 ? pt_rdata[31:16] : 16'd0;
			out_data_q.point_amp     <= hit_s1 ? pt_rdata[15:0] : 16'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
endmodule
`default_nettype wire
